FILE: rtl/hysteresis_edge_linking_3x3_unit_macros.svh
// Assertion macros shared by the checker of the edge linking unit.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef HYSTERESIS_EDGE_LINKING_3X3_UNIT_MACROS_SVH
`define HYSTERESIS_EDGE_LINKING_3X3_UNIT_MACROS_SVH

// Checked at every clock edge outside reset.
`define HEL_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every clock edge, reset included.
`define HEL_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/hel_pkg.sv
// Package for the 3x3 hysteresis edge linking unit: sizes, codes, word types
// and the frame size clamp functions. No dependencies.
`timescale 1ns / 1ps

package hel_pkg;

    // Line store depth and the column counter width that follows from it
    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);

    // Fixed field widths
    localparam int OUT_COL_W  = 11;
    localparam int ROW_W      = 12;
    localparam int PIX_W      = 8;
    localparam int FRAME_W_W  = 12;
    localparam int FRAME_H_W  = 13;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;

    localparam int HEIGHT_LIMIT        = 4096;
    localparam int RESET_FRAME_WIDTH   = 640;
    localparam int RESET_FRAME_HEIGHT  = 480;

    localparam logic [PIX_W-1:0] WEAK_VALUE   = 8'd20;
    localparam logic [PIX_W-1:0] STRONG_VALUE = 8'd255;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Result queue; an input word is taken only while the queue leaves
    // room for two results in flight plus two from the new word.
    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int ACCEPT_LIMIT = FIFO_DEPTH - 4;

    // One pixel on its way from the counters to the window stage
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] pixel;
        logic             interior;
        logic             border;
        logic             frame_end;
    } hel_item_t;

    // One output word
    typedef struct packed {
        logic [OUT_COL_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic [PIX_W-1:0]     pixel;
        logic                 last;
        logic                 done;
    } hel_result_t;

    // Zero, one or two results written into the queue in one cycle
    typedef struct packed {
        logic [1:0]  count;
        hel_result_t first;
        hel_result_t second;
    } hel_push_t;

    // One entry of the line store: both rows above at one column
    typedef struct packed {
        logic [PIX_W-1:0] two_above;
        logic [PIX_W-1:0] above;
    } hel_line_t;

    // Last column index for a programmed width (0 acts as 1, clamp at MAX_WIDTH)
    function automatic logic [COL_W-1:0] last_col_of(input logic [FRAME_W_W-1:0] w);
        if (w == '0)
            return '0;
        else if (int'(w) > MAX_WIDTH)
            return COL_W'(MAX_WIDTH - 1);
        else
            return COL_W'(w - 1'b1);
    endfunction

    // Last row index for a programmed height (0 acts as 1, clamp at 4096)
    function automatic logic [ROW_W-1:0] last_row_of(input logic [FRAME_H_W-1:0] h);
        if (h == '0)
            return '0;
        else if (int'(h) > HEIGHT_LIMIT)
            return ROW_W'(HEIGHT_LIMIT - 1);
        else
            return ROW_W'(h - 1'b1);
    endfunction

endpackage

FILE: rtl/hel_line_ram.sv
// Line store RAM: one entry per column holding the two rows above.
// Synchronous write, registered read. Uses hel_pkg.
`timescale 1ns / 1ps

module hel_line_ram
    import hel_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    output hel_line_t        rd_data,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  hel_line_t        wr_data
);

    hel_line_t mem_reg [MAX_WIDTH];
    hel_line_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port, registered on rd_en
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/hel_window.sv
// 3x3 window stage: holds the two previous columns, links weak pixels and
// forms the results of one pixel. Uses hel_pkg.
`timescale 1ns / 1ps

module hel_window
    import hel_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      clear,
    input  logic      valid,
    input  hel_item_t item,
    input  hel_line_t line,
    output hel_push_t push,
    output hel_line_t wr_line
);

    // Columns c-2 (0..2) and c-1 (3..5) as top, middle, bottom
    logic [PIX_W-1:0] win_reg [6];
    logic             strong_near;
    logic [PIX_W-1:0] linked;
    hel_result_t      inner_res;
    hel_result_t      edge_res;

    // Any strong neighbor of the center pixel
    always_comb
    begin
        strong_near = (win_reg[0] == STRONG_VALUE) || (win_reg[1] == STRONG_VALUE) ||
                      (win_reg[2] == STRONG_VALUE) || (win_reg[3] == STRONG_VALUE) ||
                      (win_reg[5] == STRONG_VALUE) || (line.two_above == STRONG_VALUE) ||
                      (line.above == STRONG_VALUE) || (item.pixel == STRONG_VALUE);
        if (win_reg[4] == WEAK_VALUE)
            linked = strong_near ? STRONG_VALUE : '0;
        else
            linked = win_reg[4];
    end

    // Interior result first, border result second
    always_comb
    begin
        inner_res.col   = OUT_COL_W'(item.col - 1'b1);
        inner_res.row   = item.row - 1'b1;
        inner_res.pixel = linked;
        inner_res.last  = !item.border;
        inner_res.done  = 1'b0;

        edge_res.col    = OUT_COL_W'(item.col);
        edge_res.row    = item.row;
        edge_res.pixel  = item.pixel;
        edge_res.last   = 1'b1;
        edge_res.done   = item.frame_end;

        push.count  = valid ? ({1'b0, item.interior} + {1'b0, item.border}) : 2'd0;
        push.first  = item.interior ? inner_res : edge_res;
        push.second = edge_res;
    end

    // Line store update: middle row moves up, new pixel becomes the row above
    assign wr_line.two_above = line.above;
    assign wr_line.above     = item.pixel;

    // Window shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (clear)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (valid)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= line.two_above;
            win_reg[4] <= line.above;
            win_reg[5] <= item.pixel;
        end
    end

endmodule

FILE: rtl/hel_out_fifo.sv
// Result queue: takes up to two results a cycle, gives one word a cycle while popped.
// Uses hel_pkg.
`timescale 1ns / 1ps

module hel_out_fifo
    import hel_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  hel_push_t             push,
    input  logic                  pop,
    output hel_result_t           head,
    output logic [FIFO_CNT_W-1:0] count
);

    hel_result_t           mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_plus1] <= push.second;
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

FILE: rtl/hysteresis_edge_linking_3x3_unit.sv
// Top level of the 3x3 hysteresis edge linking unit.
// Depends on hel_pkg, hel_line_ram, hel_window and hel_out_fifo.
//
// Usage: pixels of a frame enter on pixel/in_valid in raster order; a word is
// taken at a clock edge with in_valid high and in_stall low. Results leave on
// out_col/out_row/out_pixel/last_of_run/frame_done with out_valid, taken when
// out_stall is low. A pixel gives zero, one or two results: a border pixel
// right away, an interior pixel once the pixel below right of it arrives.
// Path: an accepted pixel is registered with the line store read, then its
// results are written into the result queue, whose head drives the output.
// Throughput: one pixel per cycle while in_stall is low, limited by the single
// output port; the line store RAM is read once and written once per pixel.
// Words with two results are absorbed by an 8-entry result queue; in_stall
// rises while more than four results wait. When the receiver stalls, the
// head word holds and the queue fills until in_stall stops the input.
// Reset: frame size 640 x 480, position (0, 0), window cleared, queue empty.
// Any write of frame_width or frame_height (cfg_index 0 or 1) restarts the
// frame; write only while the unit is idle.
`timescale 1ns / 1ps

module hysteresis_edge_linking_3x3_unit
    import hel_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // Input pixels
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PIX_W-1:0]     pixel,
    // Results
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [OUT_COL_W-1:0] out_col,
    output logic [ROW_W-1:0]     out_row,
    output logic [PIX_W-1:0]     out_pixel,
    output logic                 last_of_run,
    output logic                 frame_done
);

    logic [COL_W-1:0]      width_last_reg;
    logic [ROW_W-1:0]      height_last_reg;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic                  b_valid_reg;
    hel_item_t             b_item_reg;
    hel_item_t             item;
    logic                  in_acc;
    logic                  restart;
    logic                  col_end, row_end;
    hel_line_t             rd_line;
    hel_line_t             wr_line;
    hel_push_t             push;
    hel_result_t           head;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic                  pop;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (fifo_count > FIFO_CNT_W'(ACCEPT_LIMIT));
    assign restart  = cfg_we && ((cfg_index == REG_FRAME_WIDTH) ||
                                 (cfg_index == REG_FRAME_HEIGHT));

    // Configuration registers, kept as last column and last row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_last_reg  <= last_col_of(FRAME_W_W'(RESET_FRAME_WIDTH));
            height_last_reg <= last_row_of(FRAME_H_W'(RESET_FRAME_HEIGHT));
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_last_reg  <= last_col_of(cfg_data[FRAME_W_W-1:0]);
                REG_FRAME_HEIGHT: height_last_reg <= last_row_of(cfg_data[FRAME_H_W-1:0]);
                default:          ;
            endcase
        end
    end

    // Raster position of the next pixel
    assign col_end = (col_reg == width_last_reg);
    assign row_end = (row_reg == height_last_reg);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_acc)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Classify the incoming pixel
    always_comb
    begin
        item.col       = col_reg;
        item.row       = row_reg;
        item.pixel     = pixel;
        item.interior  = (col_reg[COL_W-1:1] != '0) && (row_reg[ROW_W-1:1] != '0);
        item.border    = (row_reg == '0) || row_end || (col_reg == '0) || col_end;
        item.frame_end = col_end && row_end;
    end

    // Window stage register, in step with the line store read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= in_acc;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            b_item_reg <= item;
    end

    hel_line_ram u_line_ram (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (col_reg),
        .rd_data (rd_line),
        .wr_en   (b_valid_reg),
        .wr_addr (b_item_reg.col),
        .wr_data (wr_line)
    );

    hel_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (restart),
        .valid   (b_valid_reg),
        .item    (b_item_reg),
        .line    (rd_line),
        .push    (push),
        .wr_line (wr_line)
    );

    // Result queue and output port
    assign pop = out_valid && !out_stall;

    hel_out_fifo u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .count (fifo_count)
    );

    assign out_valid   = (fifo_count != '0);
    assign out_col     = head.col;
    assign out_row     = head.row;
    assign out_pixel   = head.pixel;
    assign last_of_run = head.last;
    assign frame_done  = head.done;

endmodule

FILE: rtl/hel_checker.sv
// Port checker for the edge linking unit, bound to the top level.
// Uses hel_pkg and hysteresis_edge_linking_3x3_unit_macros.svh.
`timescale 1ns / 1ps
`include "hysteresis_edge_linking_3x3_unit_macros.svh"

module hel_checker
    import hel_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [OUT_COL_W-1:0] out_col,
    input logic [ROW_W-1:0]     out_row,
    input logic [PIX_W-1:0]     out_pixel,
    input logic                 last_of_run,
    input logic                 frame_done
);

    // Nothing leaves the unit while reset is held
    `HEL_ASSERT_ALWAYS(a_no_out_in_reset, !rst_n |-> !out_valid, "output word during reset")

    // A stalled output word holds
    `HEL_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_col) && $stable(out_row) && $stable(out_pixel) && $stable(last_of_run) && $stable(frame_done), "stalled output word changed")

    // End of frame is always the last result of its pixel
    `HEL_ASSERT(a_done_is_last, out_valid && frame_done |-> last_of_run, "frame_done without last_of_run")

    // An interior result is followed at once by the border pixel below right
    `HEL_ASSERT(a_pair_follows, out_valid && !out_stall && !last_of_run |=> out_valid && (out_col == $past(out_col) + 1'b1) && (out_row == $past(out_row) + 1'b1), "second result of a pair missing or misplaced")

endmodule

bind hysteresis_edge_linking_3x3_unit hel_checker u_hel_checker (.*);

FILE: verif/tb.sv
// Self-checking testbench for the 3x3 hysteresis edge linking unit.
// Drives raster pixels and frame size writes and checks every output word
// against a cycle-free predictor. Depends on hel_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb;
    import hel_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int PHASES        = 20;
    localparam int HOLD_PHASE    = 4;
    localparam int DIR_STEPS     = 32;

    // Register indexes the unit must ignore
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef enum bit {DO_PIXEL, DO_WRITE} step_kind_t;

    typedef struct packed {
        step_kind_t           kind;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
        bit                   typed;
        hel_result_t          want;
    } dir_step_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [PIX_W-1:0]     pixel;
    logic                 out_valid;
    logic                 out_stall;
    logic [OUT_COL_W-1:0] out_col;
    logic [ROW_W-1:0]     out_row;
    logic [PIX_W-1:0]     out_pixel;
    logic                 last_of_run;
    logic                 frame_done;

    // Predictor state: two rows above, window of the last two columns, position
    logic [PIX_W-1:0]     row_m1_pix [MAX_WIDTH];
    logic [PIX_W-1:0]     row_m2_pix [MAX_WIDTH];
    logic [PIX_W-1:0]     nbr_win [6];
    int                   pos_col = 0;
    int                   pos_row = 0;
    logic [FRAME_W_W-1:0] width_reg = RESET_FRAME_WIDTH;
    logic [FRAME_H_W-1:0] height_reg = RESET_FRAME_HEIGHT;

    hel_result_t awaited [$];

    int  idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_asked = 1'b0;
    int  cycle_count = 0;
    int  mismatches = 0;
    int  pixels_sent = 0;
    int  reg_writes = 0;
    int  words_checked = 0;
    int  frames_seen = 0;

    // Directed rows: typed results only where obvious from the frame size
    dir_step_t dir_table [DIR_STEPS] = '{
        '{DO_PIXEL, '0, 13'd0,   1'b1, '{11'd0, 12'd0, 8'd0,   1'b1, 1'b0}},
        '{DO_PIXEL, '0, 13'd255, 1'b1, '{11'd1, 12'd0, 8'd255, 1'b1, 1'b0}},
        '{DO_PIXEL, '0, 13'd20,  1'b1, '{11'd2, 12'd0, 8'd20,  1'b1, 1'b0}},
        '{DO_WRITE, REG_FRAME_WIDTH,  13'd1, 1'b0, '0},
        '{DO_WRITE, REG_FRAME_HEIGHT, 13'd1, 1'b0, '0},
        '{DO_PIXEL, '0, 13'd20,  1'b1, '{11'd0, 12'd0, 8'd20,  1'b1, 1'b1}},
        '{DO_PIXEL, '0, 13'd255, 1'b1, '{11'd0, 12'd0, 8'd255, 1'b1, 1'b1}},
        '{DO_WRITE, REG_FRAME_WIDTH,  13'd0, 1'b0, '0},
        '{DO_WRITE, REG_FRAME_HEIGHT, 13'd0, 1'b0, '0},
        '{DO_PIXEL, '0, 13'd7,   1'b1, '{11'd0, 12'd0, 8'd7,   1'b1, 1'b1}},
        '{DO_WRITE, REG_SPARE_HI, 13'h1FFF, 1'b0, '0},
        '{DO_PIXEL, '0, 13'd128, 1'b1, '{11'd0, 12'd0, 8'd128, 1'b1, 1'b1}},
        '{DO_WRITE, REG_FRAME_WIDTH,  13'd3, 1'b0, '0},
        '{DO_WRITE, REG_FRAME_HEIGHT, 13'd3, 1'b0, '0},
        // 3x3 frame: weak center, strong corner top left
        '{DO_PIXEL, '0, 13'd255, 1'b0, '0},
        '{DO_PIXEL, '0, 13'd0,   1'b0, '0},
        '{DO_PIXEL, '0, 13'd0,   1'b0, '0},
        '{DO_PIXEL, '0, 13'd0,   1'b0, '0},
        '{DO_PIXEL, '0, 13'd20,  1'b0, '0},
        '{DO_PIXEL, '0, 13'd0,   1'b0, '0},
        '{DO_PIXEL, '0, 13'd0,   1'b0, '0},
        '{DO_PIXEL, '0, 13'd0,   1'b0, '0},
        '{DO_PIXEL, '0, 13'd0,   1'b0, '0},
        // 3x3 frame: weak center, strong pixel is the one that closes the window
        '{DO_PIXEL, '0, 13'd0,   1'b0, '0},
        '{DO_PIXEL, '0, 13'd0,   1'b0, '0},
        '{DO_PIXEL, '0, 13'd0,   1'b0, '0},
        '{DO_PIXEL, '0, 13'd0,   1'b0, '0},
        '{DO_PIXEL, '0, 13'd20,  1'b0, '0},
        '{DO_PIXEL, '0, 13'd0,   1'b0, '0},
        '{DO_PIXEL, '0, 13'd0,   1'b0, '0},
        '{DO_PIXEL, '0, 13'd0,   1'b0, '0},
        '{DO_PIXEL, '0, 13'd255, 1'b0, '0}
    };

    hysteresis_edge_linking_3x3_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel       (pixel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_col     (out_col),
        .out_row     (out_row),
        .out_pixel   (out_pixel),
        .last_of_run (last_of_run),
        .frame_done  (frame_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Linked output words caused by one accepted pixel; advances the position
    function automatic void predict_link(input logic [PIX_W-1:0] p, output int n,
                                         output hel_result_t res [2]);
        int               w;
        int               h;
        int               c;
        int               r;
        logic [PIX_W-1:0] up2;
        logic [PIX_W-1:0] up1;
        logic [PIX_W-1:0] center;
        bit               strong_near;

        w = (width_reg == '0) ? 1 : int'(width_reg);
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        h = (height_reg == '0) ? 1 : int'(height_reg);
        if (h > HEIGHT_LIMIT)
            h = HEIGHT_LIMIT;
        c = pos_col;
        r = pos_row;
        if (c >= w || r >= h)
        begin
            c = 0;
            r = 0;
        end
        up2 = row_m2_pix[c];
        up1 = row_m1_pix[c];
        n = 0;
        res[0] = '0;
        res[1] = '0;

        // Interior pixel one up and one left now has its full window
        if (c >= 2 && r >= 2)
        begin
            center = nbr_win[4];
            if (center == WEAK_VALUE)
            begin
                strong_near = nbr_win[0] == STRONG_VALUE || nbr_win[1] == STRONG_VALUE ||
                              nbr_win[2] == STRONG_VALUE || nbr_win[3] == STRONG_VALUE ||
                              nbr_win[5] == STRONG_VALUE || up2 == STRONG_VALUE ||
                              up1 == STRONG_VALUE || p == STRONG_VALUE;
                center = strong_near ? STRONG_VALUE : '0;
            end
            res[n].col   = OUT_COL_W'(c - 1);
            res[n].row   = ROW_W'(r - 1);
            res[n].pixel = center;
            n++;
        end

        // Border pixels pass straight through
        if (r == 0 || r == h - 1 || c == 0 || c == w - 1)
        begin
            res[n].col   = OUT_COL_W'(c);
            res[n].row   = ROW_W'(r);
            res[n].pixel = p;
            n++;
        end

        if (n > 0)
        begin
            res[n - 1].last = 1'b1;
            if (c == w - 1 && r == h - 1)
                res[n - 1].done = 1'b1;
        end

        row_m2_pix[c] = up1;
        row_m1_pix[c] = p;
        nbr_win[0] = nbr_win[3];
        nbr_win[1] = nbr_win[4];
        nbr_win[2] = nbr_win[5];
        nbr_win[3] = up2;
        nbr_win[4] = up1;
        nbr_win[5] = p;

        if (c + 1 >= w)
        begin
            pos_col = 0;
            pos_row = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            pos_col = c + 1;
            pos_row = r;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // One pixel word: optional random gap, then hold until taken
    task automatic send_pixel(input logic [PIX_W-1:0] p, input bit typed,
                              input hel_result_t typed_res);
        int          n;
        int          i;
        hel_result_t res [2];

        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        pixel    <= p;
        do @(posedge clk); while (in_stall);
        predict_link(p, n, res);
        if (typed)
            awaited.push_back(typed_res);
        else
            for (i = 0; i < n; i++)
                awaited.push_back(res[i]);
        pixels_sent++;
    endtask

    // Let every expected word drain, then allow for pixels with no result yet
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Raises the write enable; the caller lowers it after the last write
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        int j;

        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        reg_writes++;
        if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT)
        begin
            if (idx == REG_FRAME_WIDTH)
                width_reg = data[FRAME_W_W-1:0];
            else
                height_reg = data[FRAME_H_W-1:0];
            pos_col = 0;
            pos_row = 0;
            for (j = 0; j < 6; j++)
                nbr_win[j] = '0;
        end
    endtask

    // Output side: random stalls, plus one long hold-off to fill the unit
    initial
    begin
        bit served;

        served = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asked && !served)
            begin
                served = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each taken output word with the oldest expected one
    always @(posedge clk)
    begin
        hel_result_t want;

        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited.size() == 0)
                report_mismatch("unexpected word at col", out_col, -1);
            else
            begin
                want = awaited.pop_front();
                words_checked++;
                if (want.done)
                    frames_seen++;
                if (out_col !== want.col)
                    report_mismatch("out_col", out_col, want.col);
                if (out_row !== want.row)
                    report_mismatch("out_row", out_row, want.row);
                if (out_pixel !== want.pixel)
                    report_mismatch($sformatf("out_pixel (%0d,%0d)", want.col, want.row),
                                    out_pixel, want.pixel);
                if (last_of_run !== want.last)
                    report_mismatch($sformatf("last_of_run (%0d,%0d)", want.col, want.row),
                                    last_of_run, want.last);
                if (frame_done !== want.done)
                    report_mismatch($sformatf("frame_done (%0d,%0d)", want.col, want.row),
                                    frame_done, want.done);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still awaited",
                     cycle_count, awaited.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int               i;
        int               k;
        int               roll;
        int               n_items;
        int               w_data;
        int               h_data;
        logic [PIX_W-1:0] px;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pixel     = '0;
        for (i = 0; i < MAX_WIDTH; i++)
        begin
            row_m1_pix[i] = '0;
            row_m2_pix[i] = '0;
        end
        for (i = 0; i < 6; i++)
            nbr_win[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        for (i = 0; i < DIR_STEPS; i++)
        begin
            if (dir_table[i].kind == DO_WRITE)
            begin
                wait_idle();
                reg_write(dir_table[i].index, dir_table[i].data);
                cfg_we <= 1'b0;
            end
            else
                send_pixel(dir_table[i].data[PIX_W-1:0], dir_table[i].typed,
                           dir_table[i].want);
        end

        // Random frames, mostly small, with the size extremes mixed in
        for (k = 0; k < PHASES; k++)
        begin
            case (k % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 82; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            w_data  = $urandom_range(1, 14);
            h_data  = $urandom_range(1, 9);
            n_items = $urandom_range(40, 110);
            case (k)
                2:  begin w_data = 13'h1FFF; h_data = 2;        n_items = 300;  end
                4:  begin w_data = 10;       h_data = 6;        n_items = 200;  end
                6:  begin w_data = 1;        h_data = 13'h1FFF; n_items = 100;  end
                9:  begin w_data = 0;        h_data = 0;        n_items = 30;   end
                12: begin w_data = MAX_WIDTH; h_data = HEIGHT_LIMIT; n_items = 80; end
                14: begin w_data = 3;        h_data = 3;        n_items = 90;   end
                default: ;
            endcase

            wait_idle();
            if ($urandom_range(1) == 1)
                reg_write(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                          CFG_W'($urandom));
            reg_write(REG_FRAME_WIDTH, CFG_W'(w_data));
            reg_write(REG_FRAME_HEIGHT, CFG_W'(h_data));
            cfg_we <= 1'b0;
            if (k == HOLD_PHASE)
                hold_asked <= 1'b1;

            // Weak and strong values dominate so that linking decisions happen
            for (i = 0; i < n_items; i++)
            begin
                roll = $urandom_range(99);
                if (roll < 40)
                    px = WEAK_VALUE;
                else if (roll < 70)
                    px = STRONG_VALUE;
                else
                    px = PIX_W'($urandom_range(255));
                send_pixel(px, 1'b0, '0);
            end
        end

        wait_idle();
        $display("Sent %0d pixels over %0d frame settings with %0d register writes.",
                 pixels_sent, PHASES, reg_writes);
        $display("Checked %0d output words covering %0d frame ends.",
                 words_checked, frames_seen);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
